### rtl/square_window_rotate_defines.svh
// Assertion helpers shared by the RTL that checks itself.
// Both expect clk and arst_n in scope.
`ifndef SQUARE_WINDOW_ROTATE_DEFINES_SVH
`define SQUARE_WINDOW_ROTATE_DEFINES_SVH

// Same-cycle implication.
`define SWR_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("square_window_rotate: assertion failed");

// Next-cycle implication.
`define SWR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("square_window_rotate: assertion failed");

`endif

### rtl/sqwr_pkg.sv
package sqwr_pkg;

	localparam int DEF_MAX_SIDE = 64;
	localparam int RESET_SIDE   = 64;
	localparam int SIZE_W       = 7;
	localparam int VAL_W        = 13;
	localparam int COORD_W      = 6;
	localparam int RAD_W        = 5;
	localparam int QUEUE_DEPTH  = 2;

	// Opcodes of an input beat
	localparam logic [1:0] OP_INIT   = 2'd0;
	localparam logic [1:0] OP_ROTATE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Work kinds handed from front to back
	typedef enum logic [1:0] {
		K_INIT = 2'd0,
		K_ROT  = 2'd1,
		K_READ = 2'd2,
		K_NONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic [RAD_W-1:0]   radius;
		logic               direction;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] cell_value;
		logic             status;
	} res_t;

	// Classified command; for a read, top/left hold the cell coordinates
	typedef struct packed {
		kind_t              kind;
		logic               status;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] side;
		logic               ccw;
		logic [SIZE_W-1:0]  n;
	} cmd_t;

endpackage

### rtl/square_window_rotate.sv
// Square grid with window rotation.
// Input side is a queue: drive cmd and push; a beat is taken when push is
// high and full is low. Results come out of a queue: while empty is low the
// oldest result sits on result, and pop takes it. Every beat gives exactly
// one result beat, in order. grid_size is written with grid_size_we and
// takes effect for the next beat accepted.
// Accepted beats are classified and checked against the grid at once and
// wait in a two-entry command queue; a sequencer works them one at a time
// against the grid memory and a scratch memory, both with one write and one
// registered read port. Steps per beat, taken by that sequencer:
//   init   one cell written a cycle
//   rotate for side s = 2r+1: copy out, then write back turned
//   read   one grid read; rejected beats go straight to the result.
// After reset full stays high while a sweep loads the reset numbering
// into the grid. When pop is held low the result queue fills, the
// sequencer holds its finished result, and the command queue in front
// still takes up to two beats.
`include "square_window_rotate_defines.svh"

module square_window_rotate #(
	parameter int MAX_SIDE = sqwr_pkg::DEF_MAX_SIDE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  sqwr_pkg::item_t             cmd,
	output logic                        empty,
	input  logic                        pop,
	output sqwr_pkg::res_t              result,
	input  logic                        grid_size_we,
	input  logic [sqwr_pkg::SIZE_W-1:0] grid_size
);
	import sqwr_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	logic             clearing;
	logic             cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
	cmd_t             cmdq_data, cmdq_head;
	logic [CMD_W-1:0] cmdq_dout;
	logic             resq_push, resq_full;
	res_t             resq_data;
	logic [RES_W-1:0] resq_dout;

	sqwr_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.grid_size_we (grid_size_we),
		.grid_size    (grid_size),
		.clearing     (clearing),
		.cmdq_full    (cmdq_full),
		.cmdq_push    (cmdq_push),
		.cmdq_data    (cmdq_data)
	);

	sqwr_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmdq_push),
		.din    (cmdq_data),
		.full   (cmdq_full),
		.pop    (cmdq_pop),
		.dout   (cmdq_dout),
		.empty  (cmdq_empty)
	);

	assign cmdq_head = cmd_t'(cmdq_dout);

	sqwr_back #(.MAX_SIDE(MAX_SIDE)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmdq_empty (cmdq_empty),
		.cmdq_head  (cmdq_head),
		.cmdq_pop   (cmdq_pop),
		.resq_full  (resq_full),
		.resq_push  (resq_push),
		.resq_data  (resq_data),
		.clearing   (clearing)
	);

	sqwr_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (resq_push),
		.din    (resq_data),
		.full   (resq_full),
		.pop    (pop),
		.dout   (resq_dout),
		.empty  (empty)
	);

	assign result = res_t'(resq_dout);

	// checks
	`SWR_ASSERT_IMPL(a_clear_blocks, clearing, full)
	`SWR_ASSERT_IMPL(a_res_room, resq_push, !resq_full)
	`SWR_ASSERT_NEXT(a_cmd_queued, push && !full, !cmdq_empty)
	`SWR_ASSERT_IMPL(a_bad_zero, !empty && result.status, result.cell_value == '0)
endmodule

### rtl/sqwr_ram.sv
module sqwr_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port; read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/sqwr_fifo.sv
module sqwr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sqwr_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] din,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

### rtl/sqwr_front.sv
module sqwr_front #(
	parameter int MAX_SIDE = sqwr_pkg::DEF_MAX_SIDE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  sqwr_pkg::item_t             cmd,
	input  logic                        grid_size_we,
	input  logic [sqwr_pkg::SIZE_W-1:0] grid_size,
	input  logic                        clearing,
	input  logic                        cmdq_full,
	output logic                        cmdq_push,
	output sqwr_pkg::cmd_t              cmdq_data
);
	import sqwr_pkg::*;

	logic [SIZE_W-1:0]  grid_size_q;
	logic [SIZE_W-1:0]  n;
	logic [SIZE_W-1:0]  row_hi, col_hi;
	logic               win_bad, cell_bad;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= SIZE_W'(RESET_SIDE);
		end else if (grid_size_we) begin
			grid_size_q <= grid_size;
		end
	end

	// side in use: zero acts as one, clamp at MAX_SIDE
	always_comb begin
		if (grid_size_q == '0) begin
			n = SIZE_W'(1);
		end else if ({3'b000, grid_size_q} > 10'(MAX_SIDE)) begin
			n = SIZE_W'(MAX_SIDE);
		end else begin
			n = grid_size_q;
		end
	end

	// bounds checks
	assign row_hi   = {1'b0, cmd.center_row} + {2'b00, cmd.radius};
	assign col_hi   = {1'b0, cmd.center_col} + {2'b00, cmd.radius};
	assign win_bad  = (cmd.center_row < {1'b0, cmd.radius}) ||
	                  (cmd.center_col < {1'b0, cmd.radius}) ||
	                  (row_hi >= n) || (col_hi >= n);
	assign cell_bad = ({1'b0, cmd.center_row} >= n) || ({1'b0, cmd.center_col} >= n);

	// classify the beat
	always_comb begin
		cmdq_data.status = 1'b0;
		cmdq_data.top    = cmd.center_row - {1'b0, cmd.radius};
		cmdq_data.left   = cmd.center_col - {1'b0, cmd.radius};
		cmdq_data.side   = {cmd.radius, 1'b1};
		cmdq_data.ccw    = cmd.direction;
		cmdq_data.n      = n;
		case (cmd.op)
			OP_INIT: begin
				cmdq_data.kind = K_INIT;
			end
			OP_ROTATE: begin
				cmdq_data.kind   = win_bad ? K_NONE : K_ROT;
				cmdq_data.status = win_bad;
			end
			OP_READ: begin
				cmdq_data.kind   = cell_bad ? K_NONE : K_READ;
				cmdq_data.status = cell_bad;
				cmdq_data.top    = cmd.center_row;
				cmdq_data.left   = cmd.center_col;
			end
			default: begin
				cmdq_data.kind   = K_NONE;
				cmdq_data.status = 1'b1;
			end
		endcase
	end

	assign full      = cmdq_full || clearing;
	assign cmdq_push = push && !full;
endmodule

### rtl/sqwr_back.sv
module sqwr_back #(
	parameter int MAX_SIDE = sqwr_pkg::DEF_MAX_SIDE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmdq_empty,
	input  sqwr_pkg::cmd_t cmdq_head,
	output logic           cmdq_pop,
	input  logic           resq_full,
	output logic           resq_push,
	output sqwr_pkg::res_t resq_data,
	output logic           clearing
);
	import sqwr_pkg::*;

	localparam int RW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int AW    = 2 * RW;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = ((RW > COORD_W) ? RW : COORD_W) + 1;
	localparam int N0    = (MAX_SIDE < RESET_SIDE) ? MAX_SIDE : RESET_SIDE;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_INIT  = 8'b0000_0100,
		S_COPY  = 8'b0000_1000,
		S_TURN  = 8'b0001_0000,
		S_BACK  = 8'b0010_0000,
		S_READ  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [RW-1:0]     a_q, b_q;
	logic [VAL_W-1:0]  val_q;
	logic              sw_s1, gw_s1;
	logic [AW-1:0]     addr_s1;

	logic [RW-1:0]     lim_m1;
	logic              last_b, last;
	logic              in_clear;
	logic [COORD_W-1:0] s_m1;
	logic [SW-1:0]     win_row, win_col, dc_cw, dr_ccw;
	logic [RW-1:0]     dst_r, dst_c;
	logic [AW-1:0]     win_addr, dst_addr, cell_addr;

	logic              g_we, g_re, s_re;
	logic [AW-1:0]     g_waddr, g_raddr;
	logic [VAL_W-1:0]  g_wdata, g_rdata, s_rdata;

	// sweep limit per phase
	always_comb begin
		case (state_q)
			S_CLEAR: lim_m1 = RW'(MAX_SIDE - 1);
			S_INIT:  lim_m1 = RW'(cmd_q.n - SIZE_W'(1));
			default: lim_m1 = RW'(cmd_q.side - COORD_W'(1));
		endcase
	end

	assign last_b = (b_q == lim_m1);
	assign last   = last_b && (a_q == lim_m1);

	// reset numbering covers only the reset side; the rest is zeroed
	assign in_clear = ({1'b0, a_q} < (RW + 1)'(N0)) && ({1'b0, b_q} < (RW + 1)'(N0));

	// window source and scratch destination coordinates
	assign s_m1     = cmd_q.side - COORD_W'(1);
	assign win_row  = SW'(cmd_q.top) + SW'(a_q);
	assign win_col  = SW'(cmd_q.left) + SW'(b_q);
	assign win_addr = {win_row[RW-1:0], win_col[RW-1:0]};
	assign dc_cw    = SW'(s_m1) - SW'(a_q);
	assign dr_ccw   = SW'(s_m1) - SW'(b_q);
	assign dst_r    = cmd_q.ccw ? dr_ccw[RW-1:0] : b_q;
	assign dst_c    = cmd_q.ccw ? a_q : dc_cw[RW-1:0];
	assign dst_addr = {dst_r, dst_c};
	assign cell_addr = {RW'(cmd_q.top), RW'(cmd_q.left)};

	// grid memory ports
	assign g_we    = (state_q == S_CLEAR) || (state_q == S_INIT) || gw_s1;
	assign g_waddr = gw_s1 ? addr_s1 : {a_q, b_q};
	always_comb begin
		if (gw_s1) begin
			g_wdata = s_rdata;
		end else if (state_q == S_INIT || in_clear) begin
			g_wdata = val_q;
		end else begin
			g_wdata = '0;
		end
	end
	assign g_re    = (state_q == S_COPY) || (state_q == S_READ);
	assign g_raddr = (state_q == S_READ) ? cell_addr : win_addr;
	assign s_re    = (state_q == S_BACK);

	sqwr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grid (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (g_re),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	sqwr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_scratch (
		.clk   (clk),
		.we    (sw_s1),
		.waddr (addr_s1),
		.wdata (g_rdata),
		.re    (s_re),
		.raddr ({a_q, b_q}),
		.rdata (s_rdata)
	);

	// write stage behind the registered reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_s1 <= 1'b0;
			gw_s1 <= 1'b0;
		end else begin
			sw_s1 <= (state_q == S_COPY);
			gw_s1 <= (state_q == S_BACK);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= (state_q == S_COPY) ? dst_addr : win_addr;
	end

	// handshakes
	assign cmdq_pop  = (state_q == S_IDLE) && !cmdq_empty;
	assign resq_push = (state_q == S_DONE) && !resq_full;
	assign resq_data.cell_value = (cmd_q.kind == K_READ) ? g_rdata : '0;
	assign resq_data.status     = cmd_q.status;
	assign clearing  = (state_q == S_CLEAR);

	// command register
	always_ff @(posedge clk) begin
		if (cmdq_pop) begin
			cmd_q <= cmdq_head;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			a_q     <= '0;
			b_q     <= '0;
			val_q   <= VAL_W'(1);
		end else begin
			case (state_q)
				S_CLEAR, S_INIT, S_COPY, S_BACK: begin
					if (state_q == S_INIT || (state_q == S_CLEAR && in_clear)) begin
						val_q <= val_q + VAL_W'(1);
					end
					b_q <= last_b ? '0 : b_q + RW'(1);
					if (last) begin
						a_q <= '0;
					end else if (last_b) begin
						a_q <= a_q + RW'(1);
					end
					if (last) begin
						case (state_q)
							S_COPY:  state_q <= S_TURN;
							S_CLEAR: state_q <= S_IDLE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_IDLE: begin
					a_q   <= '0;
					b_q   <= '0;
					val_q <= VAL_W'(1);
					if (!cmdq_empty) begin
						case (cmdq_head.kind)
							K_INIT:  state_q <= S_INIT;
							K_ROT:   state_q <= S_COPY;
							K_READ:  state_q <= S_READ;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_TURN: begin
					state_q <= S_BACK;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!resq_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
